>>> src/scal_pkg.sv
// Shared constants, angle table and widths for the segment geometry pipeline.
package scal_pkg;

    localparam int DEF_COORD_BITS    = 12;
    localparam int DEF_CORDIC_STAGES = 16;

    // Fraction bits of the rotated vector and headroom bits above the coordinate width.
    localparam int FRAC_BITS   = 16;
    localparam int VEC_EXTRA   = 20;

    // Angle in units of 2^-16 degree; 26 bits hold the worst case of about 190 degrees.
    localparam int ANGLE_BITS  = 26;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_BITS    = 22;

    localparam logic signed [ANGLE_BITS-1:0] DEG90 = ANGLE_BITS'(5898240);

    localparam int HEADING_BITS  = 15;
    localparam int SPAN_BITS     = 15;
    localparam int HEADING_MAX   = 11520;
    localparam int HEADING_ROUND = 512;
    localparam int HEADING_SHIFT = 10;

    localparam int GAIN      = 636751;
    localparam int GAIN_BITS = 20;
    localparam int SPAN_MAX  = 32767;
    localparam int SPAN_SHIFT = FRAC_BITS + 18;

    localparam logic [ATAN_BITS-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    // atan(2^-i) in 2^-16 degree; zero past the end of the table.
    function automatic logic signed [ANGLE_BITS-1:0] atan_step(input int i);
        logic signed [ANGLE_BITS-1:0] v;
        v = '0;
        if (i < ATAN_ENTRIES) begin
            v = $signed(ANGLE_BITS'(ATAN_TABLE[5'(i)]));
        end
        return v;
    endfunction

endpackage

>>> src/scal_prep.sv
// Front cell: orders the end points, forms the midpoint and pre-rotates the difference vector.
module scal_prep #(
    parameter int COORD_BITS = scal_pkg::DEF_COORD_BITS,
    parameter int XW         = scal_pkg::DEF_COORD_BITS + scal_pkg::VEC_EXTRA,
    parameter int PW         = 6 * scal_pkg::DEF_COORD_BITS + 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [COORD_BITS-1:0]                   i_ax,
    input  logic [COORD_BITS-1:0]                   i_ay,
    input  logic [COORD_BITS-1:0]                   i_bx,
    input  logic [COORD_BITS-1:0]                   i_by,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [XW-1:0]                    o_x,
    output logic signed [XW-1:0]                    o_y,
    output logic signed [scal_pkg::ANGLE_BITS-1:0]  o_z,
    output logic [PW-1:0]                           o_pay
);

    logic                                   r_valid;
    logic signed [XW-1:0]                   r_x, n_x;
    logic signed [XW-1:0]                   r_y, n_y;
    logic signed [scal_pkg::ANGLE_BITS-1:0] r_z, n_z;
    logic [PW-1:0]                          r_pay, n_pay;

    logic signed [COORD_BITS:0] dx, dy, x0, y0;
    logic signed [XW-1:0]       xe, ye;
    logic [COORD_BITS-1:0]      lx, ly, rx, ry, mx, my, adx, ady, minx, miny;
    logic                       zero;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        dx = $signed({1'b0, i_bx}) - $signed({1'b0, i_ax});
        dy = $signed({1'b0, i_ay}) - $signed({1'b0, i_by});

        // A stays on the left on a tie in x.
        if (i_ax > i_bx) begin
            lx = i_bx; ly = i_by; rx = i_ax; ry = i_ay;
        end else begin
            lx = i_ax; ly = i_ay; rx = i_bx; ry = i_by;
        end

        if (i_ax < i_bx) begin
            minx = i_ax; adx = i_bx - i_ax;
        end else begin
            minx = i_bx; adx = i_ax - i_bx;
        end
        if (i_ay < i_by) begin
            miny = i_ay; ady = i_by - i_ay;
        end else begin
            miny = i_by; ady = i_ay - i_by;
        end
        mx = minx + (adx >> 1);
        my = miny + (ady >> 1);

        zero = (i_ax == i_bx) && (i_ay == i_by);

        // Vectors in the left half plane are turned by a quarter turn first.
        if (dx[COORD_BITS]) begin
            if (!dy[COORD_BITS]) begin
                x0 = dy; y0 = -dx; n_z = scal_pkg::DEG90;
            end else begin
                x0 = -dy; y0 = dx; n_z = -scal_pkg::DEG90;
            end
        end else begin
            x0 = dx; y0 = dy; n_z = '0;
        end

        xe  = XW'(x0);
        ye  = XW'(y0);
        n_x = xe <<< scal_pkg::FRAC_BITS;
        n_y = ye <<< scal_pkg::FRAC_BITS;
        n_pay = {zero, my, mx, ry, rx, ly, lx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_pay <= n_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_pay   = r_pay;

endmodule

>>> src/scal_cell.sv
// One CORDIC vectoring cell: a single micro-rotation with its pipeline register.
module scal_cell #(
    parameter int XW    = scal_pkg::DEF_COORD_BITS + scal_pkg::VEC_EXTRA,
    parameter int PW    = 6 * scal_pkg::DEF_COORD_BITS + 1,
    parameter int STAGE = 0
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [XW-1:0]                    i_x,
    input  logic signed [XW-1:0]                    i_y,
    input  logic signed [scal_pkg::ANGLE_BITS-1:0]  i_z,
    input  logic [PW-1:0]                           i_pay,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [XW-1:0]                    o_x,
    output logic signed [XW-1:0]                    o_y,
    output logic signed [scal_pkg::ANGLE_BITS-1:0]  o_z,
    output logic [PW-1:0]                           o_pay
);

    localparam logic signed [scal_pkg::ANGLE_BITS-1:0] STEP = scal_pkg::atan_step(STAGE);

    logic                                   r_valid;
    logic signed [XW-1:0]                   r_x, n_x;
    logic signed [XW-1:0]                   r_y, n_y;
    logic signed [scal_pkg::ANGLE_BITS-1:0] r_z, n_z;
    logic [PW-1:0]                          r_pay;
    logic signed [XW-1:0]                   xs, ys;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // Arithmetic shifts round toward minus infinity, as the rotation expects.
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        if (!i_y[XW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + STEP;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_pay   = r_pay;

endmodule

>>> src/scal_post.sv
// Output cell: scales the magnitude, rounds the angle and holds the finished result.
module scal_post #(
    parameter int COORD_BITS = scal_pkg::DEF_COORD_BITS,
    parameter int XW         = scal_pkg::DEF_COORD_BITS + scal_pkg::VEC_EXTRA,
    parameter int PW         = 6 * scal_pkg::DEF_COORD_BITS + 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [XW-1:0]                    i_x,
    input  logic signed [scal_pkg::ANGLE_BITS-1:0]  i_z,
    input  logic [PW-1:0]                           i_pay,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [6*COORD_BITS-1:0]                 o_points,
    output logic [scal_pkg::HEADING_BITS-1:0]       o_heading,
    output logic [scal_pkg::SPAN_BITS-1:0]          o_span
);

    localparam int MW = XW + scal_pkg::GAIN_BITS;
    localparam int ZR = scal_pkg::ANGLE_BITS + 1;

    logic                                   r_valid;
    logic [6*COORD_BITS-1:0]                r_points;
    logic [scal_pkg::HEADING_BITS-1:0]      r_heading, n_heading;
    logic [scal_pkg::SPAN_BITS-1:0]         r_span, n_span;

    logic                                   zero;
    logic [XW-1:0]                          xp;
    logic [MW-1:0]                          prod, rnd, scaled;
    logic signed [ZR-1:0]                   zr, hs;

    assign o_ready = !r_valid || i_ready;
    assign zero    = i_pay[6*COORD_BITS];

    always_comb begin
        xp     = i_x[XW-1] ? '0 : i_x;
        prod   = MW'(xp) * MW'(scal_pkg::GAIN);
        rnd    = prod + (MW'(1) << (scal_pkg::SPAN_SHIFT - 1));
        scaled = rnd >> scal_pkg::SPAN_SHIFT;
        if (scaled > MW'(scal_pkg::SPAN_MAX)) begin
            n_span = scal_pkg::SPAN_BITS'(scal_pkg::SPAN_MAX);
        end else begin
            n_span = scaled[scal_pkg::SPAN_BITS-1:0];
        end

        zr = ZR'(i_z) + ZR'(scal_pkg::HEADING_ROUND);
        hs = zr >>> scal_pkg::HEADING_SHIFT;
        if (hs > ZR'(scal_pkg::HEADING_MAX)) begin
            n_heading = scal_pkg::HEADING_BITS'(scal_pkg::HEADING_MAX);
        end else if (hs < -ZR'(scal_pkg::HEADING_MAX)) begin
            n_heading = scal_pkg::HEADING_BITS'(-scal_pkg::HEADING_MAX);
        end else begin
            n_heading = hs[scal_pkg::HEADING_BITS-1:0];
        end

        // A segment of zero length has no direction; both results read zero.
        if (zero) begin
            n_heading = '0;
            n_span    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_points  <= i_pay[6*COORD_BITS-1:0];
            r_heading <= n_heading;
            r_span    <= n_span;
        end
    end

    assign o_valid   = r_valid;
    assign o_points  = r_points;
    assign o_heading = r_heading;
    assign o_span    = r_span;

endmodule

>>> src/segment_center_angle_length.sv
// Top level of the segment geometry pipeline: ordering, midpoint, heading and length.
//
// Use: each request on the slave stream carries the two end points of one line
// segment. For every request one result leaves on the master stream, in order,
// with the points ordered by x, the midpoint, the heading in 1/64 degree and the
// length in quarter pixels.
// From acceptance to o-side tvalid a request passes one front cell, one cell per
// micro-rotation and one output cell that holds the multiply by the inverse CORDIC gain.
// Throughput is one request per cycle while the receiver keeps m_axis_tready high.
// Every cell has its own valid bit and takes a new request whenever it is empty or
// its neighbor takes its content, so bubbles close up while the receiver stalls
// and s_axis_tready stays high until every cell holds a request.
// Reset clears all valid bits; no results are pending afterwards.
module segment_center_angle_length #(
    parameter int COORD_BITS    = scal_pkg::DEF_COORD_BITS,
    parameter int CORDIC_STAGES = scal_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // point_a_x, point_a_y, point_b_x, point_b_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // left_x, left_y, right_x, right_y, mid_x, mid_y, heading, span, zero pad
    output logic [((6*COORD_BITS+30+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int XW  = COORD_BITS + scal_pkg::VEC_EXTRA;
    localparam int PW  = 6 * COORD_BITS + 1;
    localparam int OTW = ((6*COORD_BITS + 30 + 7) / 8) * 8;
    localparam int ZW  = scal_pkg::ANGLE_BITS;

    logic                 v     [CORDIC_STAGES+1];
    logic                 rdy   [CORDIC_STAGES+1];
    logic signed [XW-1:0] x_c   [CORDIC_STAGES+1];
    logic signed [XW-1:0] y_c   [CORDIC_STAGES+1];
    logic signed [ZW-1:0] z_c   [CORDIC_STAGES+1];
    logic [PW-1:0]        pay_c [CORDIC_STAGES+1];

    logic [6*COORD_BITS-1:0]           points;
    logic [scal_pkg::HEADING_BITS-1:0] heading;
    logic [scal_pkg::SPAN_BITS-1:0]    span;

    scal_prep #(
        .COORD_BITS (COORD_BITS),
        .XW         (XW),
        .PW         (PW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_ax    (s_axis_tdata[COORD_BITS-1:0]),
        .i_ay    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_bx    (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_by    (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_x     (x_c[0]),
        .o_y     (y_c[0]),
        .o_z     (z_c[0]),
        .o_pay   (pay_c[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        scal_cell #(
            .XW    (XW),
            .PW    (PW),
            .STAGE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .o_ready (rdy[k]),
            .i_x     (x_c[k]),
            .i_y     (y_c[k]),
            .i_z     (z_c[k]),
            .i_pay   (pay_c[k]),
            .o_valid (v[k+1]),
            .i_ready (rdy[k+1]),
            .o_x     (x_c[k+1]),
            .o_y     (y_c[k+1]),
            .o_z     (z_c[k+1]),
            .o_pay   (pay_c[k+1])
        );
    end

    // The last rotation's y residue is not needed.
    scal_post #(
        .COORD_BITS (COORD_BITS),
        .XW         (XW),
        .PW         (PW)
    ) u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (v[CORDIC_STAGES]),
        .o_ready   (rdy[CORDIC_STAGES]),
        .i_x       (x_c[CORDIC_STAGES]),
        .i_z       (z_c[CORDIC_STAGES]),
        .i_pay     (pay_c[CORDIC_STAGES]),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_points  (points),
        .o_heading (heading),
        .o_span    (span)
    );

    assign m_axis_tdata = OTW'({span, heading, points});

    logic [COORD_BITS-1:0] a_lx, a_rx, a_mx;
    logic signed [scal_pkg::HEADING_BITS-1:0] a_head;

    assign a_lx   = points[COORD_BITS-1:0];
    assign a_rx   = points[3*COORD_BITS-1:2*COORD_BITS];
    assign a_mx   = points[5*COORD_BITS-1:4*COORD_BITS];
    assign a_head = $signed(heading);

    a_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> a_lx <= a_rx)
        else $error("left point lies right of the right point");

    a_mid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (a_mx >= a_lx) && (a_mx <= a_rx))
        else $error("midpoint x outside the segment");

    a_head_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (a_head <= 15'sd11520) && (a_head >= -15'sd11520))
        else $error("heading outside half a turn");

    a_front_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !v[0] |-> s_axis_tready)
        else $error("input refused while the front cell is empty");

    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && v[0] && !rdy[0]) |=> v[0])
        else $error("front cell lost its request during a stall");

endmodule

>>> tb/sv/segment_center_angle_length_tb.sv
// Self-checking testbench for the segment geometry pipeline: ordering, midpoint, heading, length.
`timescale 1ns / 1ps

module segment_center_angle_length_tb;

    localparam int COORD_MAX    = 4095;
    localparam int ANGLE_FRAC   = 16;
    localparam int ROTATIONS    = 16;
    localparam longint QUARTER_TURN = 5898240;
    localparam longint LENGTH_GAIN  = 636751;
    localparam longint HEADING_LIMIT = 11520;
    localparam longint SPAN_LIMIT    = 32767;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 2000;
    localparam int REPORT_LIMIT = 40;
    localparam int DIRECTED_COUNT = 22;

    // atan(2^-i) in 2^-16 degree, rounded to nearest.
    localparam longint ROTATION_ANGLE [ROTATIONS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic [11:0] b_y;
        logic [11:0] b_x;
        logic [11:0] a_y;
        logic [11:0] a_x;
    } segment_t;

    typedef struct packed {
        logic [14:0]        span;
        logic signed [14:0] heading;
        logic [11:0]        mid_y;
        logic [11:0]        mid_x;
        logic [11:0]        right_y;
        logic [11:0]        right_x;
        logic [11:0]        left_y;
        logic [11:0]        left_x;
    } geometry_t;

    class segment_checker;
        geometry_t   pending_geometry[$];
        int unsigned mismatches = 0;

        function geometry_t geometry_of(segment_t seg);
            geometry_t r;
            longint ax, ay, bx, by, dx, dy, x, y, z, xs, ys, hd, sp;
            ax = seg.a_x;
            ay = seg.a_y;
            bx = seg.b_x;
            by = seg.b_y;
            if (ax > bx) begin
                r.left_x = seg.b_x;
                r.left_y = seg.b_y;
                r.right_x = seg.a_x;
                r.right_y = seg.a_y;
            end else begin
                r.left_x = seg.a_x;
                r.left_y = seg.a_y;
                r.right_x = seg.b_x;
                r.right_y = seg.b_y;
            end
            r.mid_x = 12'((ax < bx) ? ax + ((bx - ax) >>> 1) : bx + ((ax - bx) >>> 1));
            r.mid_y = 12'((ay < by) ? ay + ((by - ay) >>> 1) : by + ((ay - by) >>> 1));
            dx = bx - ax;
            dy = ay - by;
            if (dx == 0 && dy == 0) begin
                hd = 0;
                sp = 0;
            end else begin
                // Vectors in the left half plane are first turned by a quarter turn.
                if (dx < 0 && dy >= 0) begin
                    x = dy;
                    y = -dx;
                    z = QUARTER_TURN;
                end else if (dx < 0) begin
                    x = -dy;
                    y = dx;
                    z = -QUARTER_TURN;
                end else begin
                    x = dx;
                    y = dy;
                    z = 0;
                end
                x = x <<< ANGLE_FRAC;
                y = y <<< ANGLE_FRAC;
                for (int i = 0; i < ROTATIONS; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + ROTATION_ANGLE[i];
                    end else begin
                        x = x - ys;
                        y = y + xs;
                        z = z - ROTATION_ANGLE[i];
                    end
                end
                hd = (z + 512) >>> 10;
                if (hd > HEADING_LIMIT) hd = HEADING_LIMIT;
                if (hd < -HEADING_LIMIT) hd = -HEADING_LIMIT;
                if (x < 0) x = 0;
                sp = (x * LENGTH_GAIN + (longint'(1) <<< 33)) >>> 34;
                if (sp > SPAN_LIMIT) sp = SPAN_LIMIT;
            end
            r.heading = 15'(hd);
            r.span = 15'(sp);
            return r;
        endfunction

        function void note_request(segment_t seg);
            pending_geometry.push_back(geometry_of(seg));
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(geometry_t got);
            geometry_t want;
            if (pending_geometry.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result expected none, actual %h", $time, got);
                return;
            end
            want = pending_geometry.pop_front();
            compare_field("left_x", want.left_x, got.left_x);
            compare_field("left_y", want.left_y, got.left_y);
            compare_field("right_x", want.right_x, got.right_x);
            compare_field("right_y", want.right_y, got.right_y);
            compare_field("mid_x", want.mid_x, got.mid_x);
            compare_field("mid_y", want.mid_y, got.mid_y);
            compare_field("heading", want.heading, got.heading);
            compare_field("span", want.span, got.span);
        endfunction

        function int pending();
            return pending_geometry.size();
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_data = '0;
    logic         m_axis_tvalid;
    logic         m_ready = 1'b0;
    logic [103:0] m_axis_tdata;

    segment_checker checker_sb = new();
    bit hold_request = 1'b0;
    int burst_left = 0;

    always #1 i_clk = ~i_clk;

    segment_center_angle_length dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_axis_tready) checker_sb.note_request(segment_t'(s_data));
            if (m_axis_tvalid && m_ready) checker_sb.check_result(geometry_t'(m_axis_tdata[101:0]));
        end
    end

    // Receiver: changes its stall pattern every so often; one long hold-off on request.
    initial begin : receiver
        int mode;
        int left;
        int cnt;
        mode = 0;
        left = 0;
        cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            cnt++;
            case (mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= (cnt % 4 == 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 9) != 0);
                end
            endcase
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) idle = 0;
            else idle++;
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    task automatic send_segment(input segment_t seg);
        s_valid <= 1'b1;
        s_data <= seg;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Steps the clock before polling, so the last accepted request is already noted.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (checker_sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [11:0] clamp_coord(int v);
        if (v < 0) return 12'd0;
        if (v > COORD_MAX) return 12'(COORD_MAX);
        return 12'(v);
    endfunction

    function automatic segment_t random_segment();
        segment_t seg;
        int shape;
        int ax, ay, span_x, span_y;
        int corners [6] = '{0, 1, 2047, 2048, 4094, 4095};
        shape = $urandom_range(0, 99);
        ax = $urandom_range(0, COORD_MAX);
        ay = $urandom_range(0, COORD_MAX);
        seg.a_x = 12'(ax);
        seg.a_y = 12'(ay);
        seg.b_x = 12'($urandom_range(0, COORD_MAX));
        seg.b_y = 12'($urandom_range(0, COORD_MAX));
        if (shape < 20) begin
            // Short segments exercise the smallest vectors the rotation sees.
            seg.b_x = clamp_coord(ax + $urandom_range(0, 16) - 8);
            seg.b_y = clamp_coord(ay + $urandom_range(0, 16) - 8);
        end else if (shape < 35) begin
            span_x = $urandom_range(0, 3) - 1;
            if ($urandom_range(0, 1)) begin
                seg.b_x = clamp_coord(ax + span_x);
            end else begin
                seg.b_y = clamp_coord(ay + span_x);
            end
        end else if (shape < 45) begin
            span_x = $urandom_range(0, COORD_MAX);
            span_y = $urandom_range(0, 1) ? span_x : -span_x;
            if ($urandom_range(0, 1)) span_x = -span_x;
            seg.b_x = clamp_coord(ax + span_x);
            seg.b_y = clamp_coord(ay + span_y);
        end else if (shape < 50) begin
            seg.b_x = seg.a_x;
            seg.b_y = seg.a_y;
        end else if (shape < 60) begin
            seg.a_x = 12'(corners[$urandom_range(0, 5)]);
            seg.a_y = 12'(corners[$urandom_range(0, 5)]);
            seg.b_x = 12'(corners[$urandom_range(0, 5)]);
            seg.b_y = 12'(corners[$urandom_range(0, 5)]);
        end
        return seg;
    endfunction

    initial begin : stimulus
        int directed [DIRECTED_COUNT][4] = '{
            '{0, 0, 0, 0}, '{4095, 4095, 4095, 4095}, '{0, 0, 4095, 4095},
            '{0, 4095, 4095, 0}, '{4095, 0, 0, 4095}, '{4095, 4095, 0, 0},
            '{4095, 100, 0, 100}, '{0, 100, 4095, 100}, '{100, 0, 100, 4095},
            '{100, 4095, 100, 0}, '{10, 10, 11, 10}, '{10, 10, 10, 11},
            '{11, 10, 10, 10}, '{10, 11, 10, 10}, '{0, 0, 1, 1},
            '{5, 7, 4, 9}, '{4095, 0, 4095, 4095}, '{0, 4095, 0, 0},
            '{2048, 2047, 2047, 2048}, '{4094, 1, 1, 4094}, '{3000, 1000, 1000, 3000},
            '{1, 4095, 0, 4094}
        };
        segment_t seg;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            seg.a_x = 12'(directed[i][0]);
            seg.a_y = 12'(directed[i][1]);
            seg.b_x = 12'(directed[i][2]);
            seg.b_y = 12'(directed[i][3]);
            pace();
            send_segment(seg);
        end
        wait_drained();

        for (int i = 0; i < 650; i++) begin
            pace();
            send_segment(random_segment());
        end

        // Keep offering back to back while the receiver holds off, so the pipeline fills.
        hold_request = 1'b1;
        for (int i = 0; i < 80; i++) send_segment(random_segment());
        burst_left = 0;
        wait_drained();

        for (int i = 0; i < 650; i++) begin
            pace();
            send_segment(random_segment());
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (checker_sb.mismatches == 0 && checker_sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
src/scal_pkg.sv
src/scal_prep.sv
src/scal_cell.sv
src/scal_post.sv
src/segment_center_angle_length.sv
tb/sv/segment_center_angle_length_tb.sv
